// File: hdl/psr_pkg.sv
`timescale 1ns / 1ps
package psr_pkg;

  // Request and result payloads
  typedef struct packed {
    logic [15:0] wavelength_um;
    logic [17:0] temperature_k;
  } psr_in_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_INVALID = 2'd2
  } psr_status_t;

  typedef struct packed {
    logic [31:0] radiance;
    psr_status_t status;
  } psr_out_t;

  // First divider: x = (C2 in Q16.16 << 30) / (w * t), 38 quotient bits kept
  localparam int X_NUM_W = 60;
  localparam int X_W     = 38;
  localparam int WT_W    = 34;
  localparam logic [X_NUM_W-1:0] C2_NUM = X_NUM_W'(64'd942925414 << 30);
  // w * t at or below this gives x of 64 or more
  localparam logic [WT_W-1:0] TINY_LIM = WT_W'(64'd3683302);

  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  // Second divider: q0 = (C1/pi in Q32 << 17) / Q
  localparam int Q0_NUM_W = 63;
  localparam int Q0_W     = 33;
  localparam int QN_W     = 31;
  localparam logic [Q0_NUM_W-1:0] C1PI_NUM = Q0_NUM_W'(64'd51155728444820 << 17);

  localparam int EM1_TERMS = 24;
  localparam logic signed [8:0] SH_BIAS = 9'sd79;

  // Context carried through the exp series stages
  typedef struct packed {
    logic [31:0] z;
    logic [31:0] term;
    logic [32:0] sum;
    logic [6:0]  n;
    logic        big;
    logic [30:0] p;
    logic [6:0]  ep;
    logic        inv;
    logic        tiny;
  } psr_ctx_t;

  typedef struct packed {
    logic        inv;
    logic        tiny;
    logic [30:0] p;
    logic [6:0]  ep;
  } psr_side1_t;

  typedef struct packed {
    logic        inv;
    logic        tiny;
    logic [6:0]  eq;
    logic [6:0]  n;
  } psr_side2_t;

  typedef struct packed {
    logic [30:0] p;
    logic        inc;
  } psr_nm_t;

  // Index of the top set bit
  function automatic logic [5:0] msb_idx(input logic [32:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // Product of two normalized mantissas, renormalized by one shift
  function automatic psr_nm_t norm_mul(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] pr;
    psr_nm_t     r;
    pr = a * b;
    if (pr[61]) begin
      r.p   = pr[61:31];
      r.inc = 1'b1;
    end else begin
      r.p   = pr[60:30];
      r.inc = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/planck_spectral_radiance.sv
`timescale 1ns / 1ps
// Blackbody spectral radiance L = C1 / (pi * lambda^5 * (exp(C2 / (lambda*T)) - 1)) in
// W/(cm2 sr um). Wavelength is unsigned Q6.10 um, temperature unsigned Q14.4 K, radiance
// unsigned Q16.16. Status is 0 for a normal result, 1 when the result saturates to all
// ones and 2 when either input is zero (radiance then reads 0); results too small return
// 0 with status 0. The block is a fixed pipeline: one request is taken every cycle unless
// in_stall is high, and its path runs through the two bit-per-stage dividers (38 and 33
// stages) and the 23 three-stage terms of the exp series. A held result does not stop
// intake while the stage in front of the output register is empty.
module planck_spectral_radiance import psr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  psr_in_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output psr_out_t out_rsp
);

  localparam int NPOW  = 4;
  localparam int NTERM = EM1_TERMS - 1;

  logic en;

  // Input stage
  logic        s0_v_r;
  logic [15:0] s0_w_r;
  logic [17:0] s0_t_r;

  // Denominator product and wavelength normalization
  logic            s1_v_r, s1_inv_r;
  logic [WT_W-1:0] s1_d_r;
  logic [30:0]     s1_a_r;
  logic [3:0]      s1_ea_r;
  logic [5:0]      s1_ea_full;
  logic [4:0]      s1_shamt;

  // Fifth power chain
  logic            pw_v_r    [NPOW];
  logic [WT_W-1:0] pw_d_r    [NPOW];
  logic            pw_inv_r  [NPOW];
  logic            pw_tiny_r [NPOW];
  logic [30:0]     pw_a_r    [NPOW];
  logic [3:0]      pw_ea_r   [NPOW];
  logic [30:0]     pw_p_r    [NPOW];
  logic [6:0]      pw_ep_r   [NPOW];

  // First divider
  psr_side1_t       d1_side_in;
  logic             d1_v;
  logic [X_W-1:0]   d1_x;
  logic [$bits(psr_side1_t)-1:0] d1_side_out;

  // Exponent range reduction
  logic           e1_v_r, e2_v_r, e3_v_r, e4_v_r;
  logic [X_W-1:0] e1_x_r;
  psr_side1_t     e1_side_r, e2_side_r, e3_side_r;
  logic [54:0]    e1_ph_r;
  logic [48:0]    e1_pl_r;
  logic [55:0]    e2_ysum;
  logic [6:0]     e2_n_r, e3_n_r;
  logic [31:0]    e2_f_r, e2_xlo_r, e3_xlo_r, e3_zh_r;
  logic           e2_big_r, e3_big_r;
  logic [63:0]    e3_zp;
  psr_ctx_t       e4_ctx_r, e4_ctx_nxt;

  // Series terms
  logic     tv   [NTERM+1];
  psr_ctx_t tctx [NTERM+1];

  // Mantissa, normalization, denominator
  logic        f1_v_r, f2_v_r, f3_v_r;
  logic [32:0] f1_mant_r, f1_mant_nxt, f1_sum, f1_sub;
  logic [33:0] f1_mwide;
  psr_ctx_t    f1_ctx_r, f2_ctx_r;
  logic [5:0]  f2_em_nxt, f2_em_r;
  logic [32:0] f2_msh;
  logic [30:0] f2_m_r;
  psr_nm_t     f3_nm;
  logic [QN_W-1:0] f3_q_r;
  psr_side2_t  f3_side_r, f3_side_nxt;

  // Second divider
  logic                          d2_v;
  logic [Q0_W-1:0]               d2_q0;
  logic [$bits(psr_side2_t)-1:0] d2_side_out;
  psr_side2_t                    d2_side;

  // Scale stage
  logic                   g1_v_r, g1_inv_r, g1_tiny_r;
  logic signed [8:0]      g1_sh_r, g1_sh_nxt;
  logic [Q0_W-1:0]        g1_q0_r;

  // Output
  logic        out_valid_r;
  psr_out_t    out_rsp_r, out_rsp_nxt;
  logic [63:0] o_q64, o_shl, o_rnd;
  logic [7:0]  o_rsh;

  // Advance unless a held result would be overwritten
  assign en       = !(out_valid_r && out_stall && g1_v_r);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
    end
  end

  assign s1_ea_full = msb_idx(33'(s0_w_r));
  assign s1_shamt   = 5'd30 - {1'b0, s1_ea_full[3:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      s0_w_r   <= in_req.wavelength_um;
      s0_t_r   <= in_req.temperature_k;
      s1_d_r   <= s0_w_r * s0_t_r;
      s1_inv_r <= (s0_w_r == '0) || (s0_t_r == '0);
      s1_a_r   <= 31'(s0_w_r) << s1_shamt;
      s1_ea_r  <= s1_ea_full[3:0];
    end
  end

  // Raise the normalized wavelength to the fifth power
  genvar j;
  generate
    for (j = 0; j < NPOW; j++) begin : g_pow
      logic            pv, pinv, ptiny;
      logic [WT_W-1:0] pd;
      logic [30:0]     pa, pp;
      logic [3:0]      pea;
      logic [6:0]      pep;
      psr_nm_t         nm;

      if (j == 0) begin : g_head
        assign pv    = s1_v_r;
        assign pd    = s1_d_r;
        assign pinv  = s1_inv_r;
        assign ptiny = (s1_d_r <= TINY_LIM);
        assign pa    = s1_a_r;
        assign pea   = s1_ea_r;
        assign pp    = s1_a_r;
        assign pep   = 7'(s1_ea_r);
      end else begin : g_link
        assign pv    = pw_v_r[j-1];
        assign pd    = pw_d_r[j-1];
        assign pinv  = pw_inv_r[j-1];
        assign ptiny = pw_tiny_r[j-1];
        assign pa    = pw_a_r[j-1];
        assign pea   = pw_ea_r[j-1];
        assign pp    = pw_p_r[j-1];
        assign pep   = pw_ep_r[j-1];
      end

      assign nm = norm_mul(pp, pa);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pw_v_r[j] <= 1'b0;
        end else if (en) begin
          pw_v_r[j] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pw_d_r[j]    <= pd;
          pw_inv_r[j]  <= pinv;
          pw_tiny_r[j] <= ptiny;
          pw_a_r[j]    <= pa;
          pw_ea_r[j]   <= pea;
          pw_p_r[j]    <= nm.p;
          pw_ep_r[j]   <= pep + 7'(pea) + 7'(nm.inc);
        end
      end
    end
  endgenerate

  always_comb begin
    d1_side_in.inv  = pw_inv_r[NPOW-1];
    d1_side_in.tiny = pw_tiny_r[NPOW-1];
    d1_side_in.p    = pw_p_r[NPOW-1];
    d1_side_in.ep   = pw_ep_r[NPOW-1];
  end

  psr_div #(
    .NW    (X_NUM_W),
    .QW    (X_W),
    .DW    (WT_W),
    .SW    ($bits(psr_side1_t)),
    .NUMER (C2_NUM)
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pw_v_r[NPOW-1]),
    .den       (pw_d_r[NPOW-1]),
    .side_i    (d1_side_in),
    .out_valid (d1_v),
    .quo       (d1_x),
    .side_o    (d1_side_out)
  );

  // Split x into power of two and fraction
  assign e2_ysum = 56'(e1_ph_r) + 56'(e1_pl_r[48:16]);
  assign e3_zp   = e2_f_r * LN2_Q32;

  always_comb begin
    e4_ctx_nxt.z    = e3_big_r ? e3_zh_r : e3_xlo_r;
    e4_ctx_nxt.term = e4_ctx_nxt.z;
    e4_ctx_nxt.sum  = '0;
    e4_ctx_nxt.n    = e3_big_r ? e3_n_r : 7'd0;
    e4_ctx_nxt.big  = e3_big_r;
    e4_ctx_nxt.p    = e3_side_r.p;
    e4_ctx_nxt.ep   = e3_side_r.ep;
    e4_ctx_nxt.inv  = e3_side_r.inv;
    e4_ctx_nxt.tiny = e3_side_r.tiny;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
      e4_v_r <= 1'b0;
    end else if (en) begin
      e1_v_r <= d1_v;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
      e4_v_r <= e3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_x_r    <= d1_x;
      e1_side_r <= psr_side1_t'(d1_side_out);
      e1_ph_r   <= d1_x[37:16] * LOG2E_Q32;
      e1_pl_r   <= d1_x[15:0] * LOG2E_Q32;
      e2_n_r    <= e2_ysum[54:48];
      e2_f_r    <= e2_ysum[47:16];
      e2_xlo_r  <= e1_x_r[31:0];
      e2_big_r  <= (e1_x_r[37:32] != '0);
      e2_side_r <= e1_side_r;
      e3_n_r    <= e2_n_r;
      e3_zh_r   <= e3_zp[63:32];
      e3_xlo_r  <= e2_xlo_r;
      e3_big_r  <= e2_big_r;
      e3_side_r <= e2_side_r;
      e4_ctx_r  <= e4_ctx_nxt;
    end
  end

  // Series for exp(z) - 1, one term per unit
  assign tv[0]   = e4_v_r;
  assign tctx[0] = e4_ctx_r;

  genvar k;
  generate
    for (k = 0; k < NTERM; k++) begin : g_term
      psr_term #(
        .DV (k + 2)
      ) u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tv[k]),
        .ctx_i     (tctx[k]),
        .out_valid (tv[k+1]),
        .ctx_o     (tctx[k+1])
      );
    end
  endgenerate

  // Add the last term and form exp(x) - 1 as a mantissa
  always_comb begin
    f1_sum      = tctx[NTERM].sum + 33'(tctx[NTERM].term);
    f1_sub      = tctx[NTERM].big ? (33'h1_0000_0000 >> tctx[NTERM].n) : 33'd0;
    f1_mwide    = (tctx[NTERM].big ? 34'h1_0000_0000 : 34'd0) + 34'(f1_sum) - 34'(f1_sub);
    f1_mant_nxt = (f1_mwide[32:0] == '0) ? 33'd1 : f1_mwide[32:0];
  end

  // Normalize the mantissa
  always_comb begin
    f2_em_nxt = msb_idx(f1_mant_r);
    if (f2_em_nxt >= 6'd30) begin
      f2_msh = f1_mant_r >> (f2_em_nxt - 6'd30);
    end else begin
      f2_msh = f1_mant_r << (6'd30 - f2_em_nxt);
    end
  end

  // Multiply into the wavelength power
  assign f3_nm = norm_mul(f2_ctx_r.p, f2_m_r);
  always_comb begin
    f3_side_nxt.inv  = f2_ctx_r.inv;
    f3_side_nxt.tiny = f2_ctx_r.tiny;
    f3_side_nxt.eq   = f2_ctx_r.ep + 7'(f2_em_r) + 7'(f3_nm.inc);
    f3_side_nxt.n    = f2_ctx_r.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= tv[NTERM];
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_mant_r <= f1_mant_nxt;
      f1_ctx_r  <= tctx[NTERM];
      f2_em_r   <= f2_em_nxt;
      f2_m_r    <= f2_msh[30:0];
      f2_ctx_r  <= f1_ctx_r;
      f3_q_r    <= f3_nm.p;
      f3_side_r <= f3_side_nxt;
    end
  end

  psr_div #(
    .NW    (Q0_NUM_W),
    .QW    (Q0_W),
    .DW    (QN_W),
    .SW    ($bits(psr_side2_t)),
    .NUMER (C1PI_NUM)
  ) u_div_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f3_v_r),
    .den       (f3_q_r),
    .side_i    (f3_side_r),
    .out_valid (d2_v),
    .quo       (d2_q0),
    .side_o    (d2_side_out)
  );

  assign d2_side   = psr_side2_t'(d2_side_out);
  assign g1_sh_nxt = SH_BIAS - $signed(9'(d2_side.eq)) - $signed(9'(d2_side.n));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r <= 1'b0;
    end else if (en) begin
      g1_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_sh_r   <= g1_sh_nxt;
      g1_q0_r   <= d2_q0;
      g1_inv_r  <= d2_side.inv;
      g1_tiny_r <= d2_side.tiny;
    end
  end

  // Scale by the exponent: saturate left shifts, round right shifts
  always_comb begin
    o_q64                = 64'(g1_q0_r);
    o_rsh                = 8'(9'sd0 - g1_sh_r);
    o_shl                = '0;
    o_rnd                = '0;
    out_rsp_nxt.radiance = '0;
    out_rsp_nxt.status   = ST_OK;
    if (g1_inv_r) begin
      out_rsp_nxt.status = ST_INVALID;
    end else if (g1_tiny_r) begin
      out_rsp_nxt.status = ST_OK;
    end else if (!g1_sh_r[8]) begin
      if (g1_sh_r[7:5] != '0) begin
        out_rsp_nxt.radiance = '1;
        out_rsp_nxt.status   = ST_SAT;
      end else begin
        o_shl = o_q64 << g1_sh_r[4:0];
        if (o_shl[63:32] != '0) begin
          out_rsp_nxt.radiance = '1;
          out_rsp_nxt.status   = ST_SAT;
        end else begin
          out_rsp_nxt.radiance = o_shl[31:0];
        end
      end
    end else if (o_rsh < 8'd63) begin
      o_rnd = (o_q64 + (64'd1 << (o_rsh - 8'd1))) >> o_rsh;
      if (o_rnd[63:32] != '0) begin
        out_rsp_nxt.radiance = '1;
        out_rsp_nxt.status   = ST_SAT;
      end else begin
        out_rsp_nxt.radiance = o_rnd[31:0];
      end
    end
  end

  // Output register: load when empty or taken, hold otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= g1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: hdl/psr_div.sv
`timescale 1ns / 1ps
module psr_div #(
  parameter int            NW    = 60,
  parameter int            QW    = 38,
  parameter int            DW    = 34,
  parameter int            SW    = 8,
  parameter logic [NW-1:0] NUMER = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_i,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_o
);

  localparam int RW = DW + 1;
  localparam logic [DW-1:0] INIT = DW'(NUMER >> QW);

  logic          v_r    [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [SW-1:0] side_r [QW];

  // One quotient bit per stage, numerator bits fed from the constant
  genvar i;
  generate
    for (i = 0; i < QW; i++) begin : g_stage
      logic          pv;
      logic [DW-1:0] prem;
      logic [DW-1:0] pden;
      logic [QW-1:0] pq;
      logic [SW-1:0] pside;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_nxt;
      logic [QW-1:0] q_nxt;

      if (i == 0) begin : g_head
        assign pv    = in_valid;
        assign prem  = INIT;
        assign pden  = den;
        assign pq    = '0;
        assign pside = side_i;
      end else begin : g_link
        assign pv    = v_r[i-1];
        assign prem  = rem_r[i-1];
        assign pden  = den_r[i-1];
        assign pq    = q_r[i-1];
        assign pside = side_r[i-1];
      end

      // Trial subtract
      always_comb begin
        trial = {prem, NUMER[QW-1-i]};
        if (trial >= {1'b0, pden}) begin
          rem_nxt = trial - {1'b0, pden};
          q_nxt   = {pq[QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {pq[QW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en) begin
          v_r[i] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i]  <= rem_nxt[DW-1:0];
          den_r[i]  <= pden;
          q_r[i]    <= q_nxt;
          side_r[i] <= pside;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[QW-1];
  assign quo       = q_r[QW-1];
  assign side_o    = side_r[QW-1];

endmodule

// File: hdl/psr_term.sv
`timescale 1ns / 1ps
module psr_term import psr_pkg::*; #(
  parameter int DV = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  psr_ctx_t ctx_i,
  output logic     out_valid,
  output psr_ctx_t ctx_o
);

  localparam int RS  = 36;
  localparam int DVW = $clog2(DV + 1);
  localparam logic [RS-1:0] RECIP = RS'((64'd1 << RS) / DV);

  logic          v1_r, v2_r, v3_r;
  psr_ctx_t      ctx1_r, ctx2_r, ctx3_r;
  psr_ctx_t      ctx1_nxt, ctx3_nxt;
  logic [31:0]   prod1_r, prod2_r, qe2_r;
  logic [63:0]   prod_full;
  logic [RS+31:0] qprod;
  logic [DVW+31:0] back;
  logic [DVW+31:0] rem;

  // Add the current term, multiply it by z
  assign prod_full = ctx_i.term * ctx_i.z;
  always_comb begin
    ctx1_nxt     = ctx_i;
    ctx1_nxt.sum = ctx_i.sum + 33'(ctx_i.term);
  end

  // Estimate the quotient by the reciprocal
  assign qprod = prod1_r * RECIP;

  // Correct the estimate by one
  assign back = qe2_r * DVW'(DV);
  assign rem  = (DVW+32)'(prod2_r) - back;
  always_comb begin
    ctx3_nxt = ctx2_r;
    if (rem >= (DVW+32)'(DV)) begin
      ctx3_nxt.term = qe2_r + 32'd1;
    end else begin
      ctx3_nxt.term = qe2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r  <= ctx1_nxt;
      prod1_r <= prod_full[63:32];
      ctx2_r  <= ctx1_r;
      prod2_r <= prod1_r;
      qe2_r   <= qprod[RS+31:RS];
      ctx3_r  <= ctx3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign ctx_o     = ctx3_r;

endmodule
